FILE: sv/priority_message_queue_unit_assert.svh
// Assertion macros used by the checker module of the priority message queue.
`ifndef PRIORITY_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define PMQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pmq: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define PMQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pmq: same-cycle check failed");

`endif

FILE: sv/pmq_pkg.sv
// Types and constants of the priority message queue.
package pmq_pkg;

	localparam int PRIO_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int FILL_W  = 5;
	localparam int STAT_W  = 2;

	typedef enum logic [STAT_W-1:0] {
		ST_PUSHED = 2'd0,
		ST_FULL   = 2'd1,
		ST_POPPED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] param_high;
		logic [BYTE_W-1:0] param_low;
	} msg_t;

	typedef struct packed {
		logic valid;
		msg_t msg;
	} cell_link_t;

	typedef struct packed {
		logic push;
		logic pop;
		msg_t new_msg;
	} cell_ctl_t;

endpackage

FILE: sv/pmq_cell.sv
// One cell of the sorted message chain: holds one message and shifts with its neighbors.
module pmq_cell import pmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_link_t left_link,
	input  logic       left_ge,
	input  cell_link_t right_link,
	output cell_link_t link,
	output logic       ge
);

	logic valid_q;
	msg_t msg_q;
	logic valid_d;
	msg_t msg_d;

	assign link.valid = valid_q;
	assign link.msg   = msg_q;

	// A push is placed behind every message of equal or higher priority.
	assign ge = valid_q && (msg_q.prio >= ctl.new_msg.prio);

	always_comb begin
		valid_d = valid_q;
		msg_d   = msg_q;
		if (ctl.push) begin
			priority if (ge) begin
				valid_d = valid_q;
				msg_d   = msg_q;
			end else if (left_ge) begin
				valid_d = 1'b1;
				msg_d   = ctl.new_msg;
			end else begin
				valid_d = left_link.valid;
				msg_d   = left_link.msg;
			end
		end else if (ctl.pop) begin
			valid_d = right_link.valid;
			msg_d   = right_link.msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		msg_q <= msg_d;
	end

endmodule

FILE: sv/priority_message_queue_unit.sv
// Top level of the priority message queue built as a sorted chain of cells.
//
//   channel   | handshake          | fields
//   ----------+--------------------+-----------------------------------------------
//   command   | start, busy        | mode, priority_req, msg_id, param_low, param_high
//   result    | done (one cycle)   | status, out_priority, out_id, out_param_low,
//             |                    | out_param_high, fill_level
//
// A beat accepted at one edge updates the whole chain at that edge
// and its result shows with done in the following cycle.
// busy stays low, so a command may be accepted at every edge.
// The chain holds DEPTH-1 messages, one cell each; every cell compares and shifts in parallel.
// Reset empties the chain at once; there is no clearing pass.
// The receiver cannot stall; each result is valid for exactly one cycle.
module priority_message_queue_unit import pmq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [BYTE_W-1:0] msg_id,
	input  logic [BYTE_W-1:0] param_low,
	input  logic [BYTE_W-1:0] param_high,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [PRIO_W-1:0] out_priority,
	output logic [BYTE_W-1:0] out_id,
	output logic [BYTE_W-1:0] out_param_low,
	output logic [BYTE_W-1:0] out_param_high,
	output logic [FILL_W-1:0] fill_level
);

	localparam int NCELL = DEPTH - 1;
	localparam int CNT_W = $clog2(DEPTH);

	cell_link_t        links [NCELL];
	logic              ges   [NCELL];
	cell_ctl_t         ctl;
	logic              accept;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W+FILL_W-1:0] count_ext;
	logic              done_q;
	status_t           status_q;
	msg_t              out_msg_q;
	logic [FILL_W-1:0] fill_q;
	status_t           status_d;
	msg_t              out_msg_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(NCELL));
	assign empty  = (count_q == '0);

	assign ctl.push            = accept && !mode && !full;
	assign ctl.pop             = accept && mode && !empty;
	assign ctl.new_msg.prio       = priority_req;
	assign ctl.new_msg.id         = msg_id;
	assign ctl.new_msg.param_high = param_high;
	assign ctl.new_msg.param_low  = param_low;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cell_link_t left_link;
		logic       left_ge;
		cell_link_t right_link;
		if (i == 0) begin : g_first
			assign left_link = '0;
			assign left_ge   = 1'b1;
		end else begin : g_mid
			assign left_link = links[i-1];
			assign left_ge   = ges[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign right_link = '0;
		end else begin : g_inner
			assign right_link = links[i+1];
		end
		pmq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_link  (left_link),
			.left_ge    (left_ge),
			.right_link (right_link),
			.link       (links[i]),
			.ge         (ges[i])
		);
	end

	always_comb begin
		count_d   = count_q;
		status_d  = ST_PUSHED;
		out_msg_d = '0;
		priority if (ctl.push) begin
			count_d  = count_q + CNT_W'(1);
			status_d = ST_PUSHED;
		end else if (ctl.pop) begin
			count_d   = count_q - CNT_W'(1);
			status_d  = ST_POPPED;
			out_msg_d = links[0].msg;
		end else if (mode) begin
			status_d = ST_EMPTY;
		end else begin
			status_d = ST_FULL;
		end
	end

	assign count_ext = {{FILL_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			out_msg_q <= out_msg_d;
			fill_q    <= count_ext[FILL_W-1:0];
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign out_priority   = out_msg_q.prio;
	assign out_id         = out_msg_q.id;
	assign out_param_low  = out_msg_q.param_low;
	assign out_param_high = out_msg_q.param_high;
	assign fill_level     = fill_q;

endmodule

FILE: sv/pmq_checker.sv
// Port-level checker of the priority message queue and its bind to the top level.
`include "priority_message_queue_unit_assert.svh"

module pmq_checker import pmq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [STAT_W-1:0] status,
	input logic [PRIO_W-1:0] out_priority,
	input logic [BYTE_W-1:0] out_id,
	input logic [BYTE_W-1:0] out_param_low,
	input logic [BYTE_W-1:0] out_param_high,
	input logic [FILL_W-1:0] fill_level
);

	logic no_payload;
	logic push_beat;

	assign no_payload = (out_priority == '0) && (out_id == '0) &&
		(out_param_low == '0) && (out_param_high == '0);
	assign push_beat = done && (status == ST_PUSHED || status == ST_FULL);

	`PMQ_ASSERT_NEXT(a_beat_answered, clk, arst_n, start && !busy, done)
	`PMQ_ASSERT_NEXT(a_no_stray_result, clk, arst_n, !(start && !busy), !done)
	`PMQ_ASSERT_NOW(a_push_no_payload, clk, arst_n, push_beat, no_payload)
	`PMQ_ASSERT_NOW(a_empty_pop_zero, clk, arst_n, done && status == ST_EMPTY, fill_level == '0 && no_payload)

endmodule

bind priority_message_queue_unit pmq_checker u_pmq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.out_priority   (out_priority),
	.out_id         (out_id),
	.out_param_low  (out_param_low),
	.out_param_high (out_param_high),
	.fill_level     (fill_level)
);

FILE: tb/testbench.sv
// Self-checking testbench of the priority message queue with a command driver and result monitor.
module testbench;
	import pmq_pkg::*;

	localparam int DEPTH = 32;
	localparam int ITEM_GOAL = 720;

	typedef struct {
		logic              mode;
		logic [PRIO_W-1:0] prio;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] plow;
		logic [BYTE_W-1:0] phigh;
		int                gap_pct;
		bit                drain;
	} command_t;

	typedef struct {
		status_t           status;
		msg_t              msg;
		logic [FILL_W-1:0] fill;
	} outcome_t;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              mode = CMD_PUSH;
	logic [PRIO_W-1:0] priority_req = '0;
	logic [BYTE_W-1:0] msg_id = '0;
	logic [BYTE_W-1:0] param_low = '0;
	logic [BYTE_W-1:0] param_high = '0;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [PRIO_W-1:0] out_priority;
	logic [BYTE_W-1:0] out_id;
	logic [BYTE_W-1:0] out_param_low;
	logic [BYTE_W-1:0] out_param_high;
	logic [FILL_W-1:0] fill_level;

	command_t pending[$];
	outcome_t due_results[$];
	msg_t     held_msgs[$];
	int       outstanding = 0;
	int       errors = 0;

	priority_message_queue_unit #(.DEPTH(DEPTH)) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.priority_req   (priority_req),
		.msg_id         (msg_id),
		.param_low      (param_low),
		.param_high     (param_high),
		.done           (done),
		.status         (status),
		.out_priority   (out_priority),
		.out_id         (out_id),
		.out_param_low  (out_param_low),
		.out_param_high (out_param_high),
		.fill_level     (fill_level)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Messages are kept sorted by priority; a new one goes behind every message of equal or
	// higher priority, so equal priorities leave in arrival order.
	function automatic outcome_t serve_command(input logic op, input msg_t m);
		outcome_t r;
		int pos;
		r.msg = '0;
		if (op == CMD_PUSH) begin
			if (held_msgs.size() == DEPTH - 1) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_msgs.size() && held_msgs[pos].prio >= m.prio)
					pos++;
				held_msgs.insert(pos, m);
				r.status = ST_PUSHED;
			end
		end else begin
			if (held_msgs.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.msg = held_msgs.pop_front();
				r.status = ST_POPPED;
			end
		end
		r.fill = FILL_W'(held_msgs.size());
		return r;
	endfunction

	task automatic add_command(input logic op, input logic [PRIO_W-1:0] p,
		input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
		command_t c;
		int idx;
		idx = pending.size();
		c.mode = op;
		c.prio = p;
		c.id = id;
		c.plow = lo;
		c.phigh = hi;
		c.gap_pct = (idx < ITEM_GOAL / 3) ? 23 : (idx < 2 * ITEM_GOAL / 3) ? 60 : 0;
		c.drain = (idx == 20 || idx == ITEM_GOAL / 3 || idx == 2 * ITEM_GOAL / 3);
		pending.push_back(c);
	endtask

	task automatic add_random(input logic op, input bit narrow);
		logic [PRIO_W-1:0] p;
		p = narrow ? PRIO_W'($urandom_range(6, 7)) : PRIO_W'($urandom_range(15));
		add_command(op, p, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
			BYTE_W'($urandom_range(255)));
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_blk
		bit took;
		int next_out;
		msg_t m;
		if (!arst_n) begin
			start <= 1'b0;
			outstanding <= 0;
		end else begin
			took = start && !busy;
			if (took) begin
				m.prio = priority_req;
				m.id = msg_id;
				m.param_high = param_high;
				m.param_low = param_low;
				due_results.push_back(serve_command(mode, m));
			end
			next_out = outstanding + int'(took) - int'(done === 1'b1);
			outstanding <= next_out;
			if (start && !took) begin
				start <= 1'b1;
			end else if (pending.size() != 0 && !(pending[0].drain && next_out != 0)
				&& $urandom_range(99) >= pending[0].gap_pct) begin
				mode <= pending[0].mode;
				priority_req <= pending[0].prio;
				msg_id <= pending[0].id;
				param_low <= pending[0].plow;
				param_high <= pending[0].phigh;
				start <= 1'b1;
				void'(pending.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_blk
		outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (due_results.size() == 0) begin
				$error("result beat with no command waiting for it");
				errors++;
			end else begin
				want = due_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (out_priority !== want.msg.prio) begin
					$error("out_priority: expected %0d, got %0d", want.msg.prio, out_priority);
					errors++;
				end
				if (out_id !== want.msg.id) begin
					$error("out_id: expected 0x%02h, got 0x%02h", want.msg.id, out_id);
					errors++;
				end
				if (out_param_low !== want.msg.param_low) begin
					$error("out_param_low: expected 0x%02h, got 0x%02h",
						want.msg.param_low, out_param_low);
					errors++;
				end
				if (out_param_high !== want.msg.param_high) begin
					$error("out_param_high: expected 0x%02h, got 0x%02h",
						want.msg.param_high, out_param_high);
					errors++;
				end
				if (fill_level !== want.fill) begin
					$error("fill_level: expected %0d, got %0d", want.fill, fill_level);
					errors++;
				end
			end
		end
	end

	initial begin
		int kind;
		int n;
		int push_pct;
		bit narrow;

		add_command(CMD_POP, 4'd0, 8'h00, 8'h00, 8'h00);
		add_command(CMD_PUSH, 4'd0, 8'h00, 8'h00, 8'h00);
		add_command(CMD_PUSH, 4'd15, 8'hFF, 8'hFF, 8'hFF);
		add_command(CMD_PUSH, 4'd15, 8'h01, 8'h80, 8'h01);
		add_command(CMD_PUSH, 4'd0, 8'h02, 8'h01, 8'h80);
		add_command(CMD_PUSH, 4'd7, 8'hAA, 8'h55, 8'hAA);
		add_command(CMD_PUSH, 4'd7, 8'h55, 8'hAA, 8'h55);
		add_command(CMD_PUSH, 4'd8, 8'h10, 8'h20, 8'h30);
		add_command(CMD_PUSH, 4'd1, 8'h11, 8'h21, 8'h31);
		for (int i = 0; i < 9; i++)
			add_command(CMD_POP, 4'd15, 8'hFF, 8'hFF, 8'hFF);
		add_command(CMD_PUSH, 4'd3, 8'h40, 8'h41, 8'h42);
		add_command(CMD_PUSH, 4'd3, 8'h43, 8'h44, 8'h45);
		add_command(CMD_POP, 4'd0, 8'h00, 8'h00, 8'h00);
		add_command(CMD_POP, 4'd0, 8'h00, 8'h00, 8'h00);

		// Random bursts drive the queue to full and back to empty; ties are made common.
		while (pending.size() < ITEM_GOAL) begin
			kind = $urandom_range(9);
			narrow = ($urandom_range(1) == 1);
			if (kind < 2) begin
				n = $urandom_range(28, 36);
				repeat (n) add_random(CMD_PUSH, narrow);
			end else if (kind < 4) begin
				n = $urandom_range(28, 36);
				repeat (n) add_random(CMD_POP, narrow);
			end else begin
				n = $urandom_range(10, 40);
				push_pct = $urandom_range(45, 65);
				repeat (n)
					add_random(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, narrow);
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || start) @(negedge clk);
		while (due_results.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (errors == 0) begin
			$display("[priority_message_queue_unit] OK");
		end else begin
			$display("[priority_message_queue_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[priority_message_queue_unit] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/pmq_pkg.sv
sv/pmq_cell.sv
sv/priority_message_queue_unit.sv
sv/pmq_checker.sv
tb/testbench.sv
